// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Each macro builds one labeled concurrent assertion on the rising clock
// edge, disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SGCM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SGCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/sgcm_pkg.sv -----
`default_nettype none

package sgcm_pkg;

   // Fixed field widths
   localparam int CODE_W    = 8;
   localparam int FRAC_IN_W = 9;

   // Curve table geometry and exact-comparison constants
   localparam int CURVE_SIZE  = 256;
   localparam int CODE_MAX    = 255;
   localparam int CURVE_NUM   = 269025;
   localparam int CURVE_OFS   = 14025;
   localparam int CURVE_STEP  = 1000;
   // Codes below this knee sit on the linear segment and linearize to zero
   localparam int LINEAR_KNEE = 11;
   localparam int WIDE_W      = 288;

   typedef logic [CODE_W-1:0]                   code_type;
   typedef logic [CURVE_SIZE-1:0][CODE_W-1:0]   curve_table_type;
   typedef logic [WIDE_W-1:0]                   wide_type;

   // Load enables of the three pipeline stages
   typedef struct packed {
      logic load_in;
      logic load_mul;
      logic load_out;
   } stage_en_type;

   // base5^5 * base12^12 in exact wide arithmetic
   function automatic wide_type pow_prod(input wide_type base5, input wide_type base12);
      wide_type acc;
      acc = wide_type'(1);
      for (int k = 0; k < 5; k++) begin
         acc = acc * base5;
      end
      for (int k = 0; k < 12; k++) begin
         acc = acc * base12;
      end
      return acc;
   endfunction

   // Build a curve table by exact comparison of 12th and 5th powers.
   // Both searches are monotonic, so one pointer walks the whole table.
   function automatic curve_table_type build_curve(input logic forward);
      wide_type        pow_r [CURVE_SIZE];
      wide_type        pow_p [CURVE_SIZE];
      curve_table_type tbl;
      int              c;
      for (int i = 0; i < CURVE_SIZE; i++) begin
         pow_r[i] = pow_prod(wide_type'(CODE_MAX), wide_type'(CURVE_STEP * i + CURVE_OFS));
         pow_p[i] = pow_prod(wide_type'(i), wide_type'(CURVE_NUM));
      end
      tbl = '0;
      c   = 0;
      if (forward) begin
         for (int i = 0; i < CURVE_SIZE; i++) begin
            while (c < CODE_MAX && pow_r[c + 1] <= pow_p[i]) begin
               c++;
            end
            tbl[i] = code_type'(c);
         end
      end else begin
         for (int i = LINEAR_KNEE; i < CURVE_SIZE; i++) begin
            while (c < CODE_MAX && pow_p[c + 1] <= pow_r[i]) begin
               c++;
            end
            tbl[i] = code_type'(c);
         end
      end
      return tbl;
   endfunction

   localparam curve_table_type TO_LINEAR = build_curve(1'b0);
   localparam curve_table_type TO_SRGB   = build_curve(1'b1);

endpackage

`default_nettype wire

// ----- rtl/core/sgcm_req_if.sv -----
`default_nettype none

interface sgcm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_red;
   logic [7:0] first_green;
   logic [7:0] first_blue;
   logic [7:0] second_red;
   logic [7:0] second_green;
   logic [7:0] second_blue;
   logic [8:0] blend_fraction;

   modport source (
      output valid, first_red, first_green, first_blue,
             second_red, second_green, second_blue, blend_fraction,
      input  ready
   );

   modport sink (
      input  valid, first_red, first_green, first_blue,
             second_red, second_green, second_blue, blend_fraction,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/sgcm_rsp_if.sv -----
`default_nettype none

interface sgcm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] mixed_red;
   logic [7:0] mixed_green;
   logic [7:0] mixed_blue;

   modport source (
      output valid, mixed_red, mixed_green, mixed_blue,
      input  ready
   );

   modport sink (
      input  valid, mixed_red, mixed_green, mixed_blue,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/sgcm_channel.sv -----
`default_nettype none

module sgcm_channel
   import sgcm_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic                   clock,
   input  stage_en_type           stage_en,
   input  code_type               first_code,
   input  code_type               second_code,
   input  logic [FRACTION_BITS:0] weight_first,
   input  logic [FRACTION_BITS:0] weight_second,
   output code_type               mixed_code
);

   localparam int PROD_W = CODE_W + FRACTION_BITS + 1;
   localparam int SUM_W  = PROD_W + 1;

   code_type          lin_first_in, lin_first_ff;
   code_type          lin_second_in, lin_second_ff;
   logic [PROD_W-1:0] prod_first_in, prod_first_ff;
   logic [PROD_W-1:0] prod_second_in, prod_second_ff;
   logic [SUM_W-1:0]  blend_sum;
   code_type          lin_mix;
   code_type          mixed_in, mixed_ff;

   // Stage 1: linearize both codes
   assign lin_first_in  = TO_LINEAR[first_code];
   assign lin_second_in = TO_LINEAR[second_code];

   always_ff @(posedge clock) begin
      if (stage_en.load_in) begin
         lin_first_ff  <= lin_first_in;
         lin_second_ff <= lin_second_in;
      end
   end

   // Stage 2: weight each linear value
   assign prod_first_in  = PROD_W'(lin_first_ff) * PROD_W'(weight_first);
   assign prod_second_in = PROD_W'(lin_second_ff) * PROD_W'(weight_second);

   always_ff @(posedge clock) begin
      if (stage_en.load_mul) begin
         prod_first_ff  <= prod_first_in;
         prod_second_ff <= prod_second_in;
      end
   end

   // Stage 3: sum, drop the fraction bits, re-encode
   assign blend_sum = SUM_W'(prod_first_ff) + SUM_W'(prod_second_ff);
   assign lin_mix   = blend_sum[FRACTION_BITS +: CODE_W];
   assign mixed_in  = TO_SRGB[lin_mix];

   always_ff @(posedge clock) begin
      if (stage_en.load_out) begin
         mixed_ff <= mixed_in;
      end
   end

   assign mixed_code = mixed_ff;

endmodule

`default_nettype wire

// ----- rtl/core/srgb_gamma_color_mix_unit.sv -----
// Gamma-correct blend of two sRGB colors.
// req_bus carries two 8-bit RGB colors and a blend fraction with
// FRACTION_BITS fraction bits; full scale gives all of the second color and
// larger values saturate to full scale. rsp_bus returns the mixed RGB color.
// Both channels use valid/ready; a transfer happens when both are high.
// Each channel goes through constant curve tables: sRGB to linear, a
// weighted sum of the two linear values, then linear back to sRGB.
// A request transfer passes table lookup, multiply, and sum and re-encode,
// each in its own register, on its way to the response valid.
// Throughput: one item per clock, sustained, with rsp_bus.ready held high.
// Stall: the result waits in the output register; the pipeline keeps
// accepting until all three stages hold an item, then req_bus.ready drops.
// Bubbles are squeezed out. Nothing is lost or repeated.
// Reset clears the stage valid bits and holds req_bus.ready low; the tables
// are constants, so the block accepts items as soon as reset is released.
`default_nettype none
`include "assert_macros.svh"

module srgb_gamma_color_mix_unit
   import sgcm_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic      clock,
   input  logic      reset,
   sgcm_req_if.sink  req_bus,
   sgcm_rsp_if.source rsp_bus
);

   localparam int WEIGHT_W = FRACTION_BITS + 1;
   localparam int CMP_W    = (WEIGHT_W > FRAC_IN_W) ? WEIGHT_W : FRAC_IN_W;
   localparam logic [CMP_W-1:0] FULL_SCALE = {{(CMP_W - 1){1'b0}}, 1'b1} << FRACTION_BITS;
   localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = FULL_SCALE[WEIGHT_W-1:0];

   stage_en_type        stage_en;
   logic                valid1_ff, valid2_ff, valid3_ff;
   logic [CMP_W-1:0]    frac_ext;
   logic [CMP_W-1:0]    frac_sat;
   logic [WEIGHT_W-1:0] weight_second_in, weight_second_ff;
   logic [WEIGHT_W-1:0] weight_first_in, weight_first_ff;

   // Advance a stage when it is empty or the stage after it advances
   assign stage_en.load_out = !valid3_ff || rsp_bus.ready;
   assign stage_en.load_mul = !valid2_ff || stage_en.load_out;
   assign stage_en.load_in  = !valid1_ff || stage_en.load_mul;

   // Refuse transfers while reset is high
   assign req_bus.ready = stage_en.load_in && !reset;
   assign rsp_bus.valid = valid3_ff;

   // Move valid bits along with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (stage_en.load_in) begin
            valid1_ff <= req_bus.valid;
         end
         if (stage_en.load_mul) begin
            valid2_ff <= valid1_ff;
         end
         if (stage_en.load_out) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   // Saturate the fraction and form both weights
   assign frac_ext         = CMP_W'(req_bus.blend_fraction);
   assign frac_sat         = (frac_ext > FULL_SCALE) ? FULL_SCALE : frac_ext;
   assign weight_second_in = frac_sat[WEIGHT_W-1:0];
   assign weight_first_in  = FULL_WEIGHT - weight_second_in;

   always_ff @(posedge clock) begin
      if (stage_en.load_in) begin
         weight_first_ff  <= weight_first_in;
         weight_second_ff <= weight_second_in;
      end
   end

   sgcm_channel #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_red (
      .clock         (clock),
      .stage_en      (stage_en),
      .first_code    (req_bus.first_red),
      .second_code   (req_bus.second_red),
      .weight_first  (weight_first_ff),
      .weight_second (weight_second_ff),
      .mixed_code    (rsp_bus.mixed_red)
   );

   sgcm_channel #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_green (
      .clock         (clock),
      .stage_en      (stage_en),
      .first_code    (req_bus.first_green),
      .second_code   (req_bus.second_green),
      .weight_first  (weight_first_ff),
      .weight_second (weight_second_ff),
      .mixed_code    (rsp_bus.mixed_green)
   );

   sgcm_channel #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_blue (
      .clock         (clock),
      .stage_en      (stage_en),
      .first_code    (req_bus.first_blue),
      .second_code   (req_bus.second_blue),
      .weight_first  (weight_first_ff),
      .weight_second (weight_second_ff),
      .mixed_code    (rsp_bus.mixed_blue)
   );

   // Back-pressure reaches the input only with every stage occupied
   `SGCM_ASSERT_IMPLY(full_when_blocked, clock, reset, !req_bus.ready, valid1_ff && valid2_ff && valid3_ff, "input blocked while a stage is empty")

   // Weights stay within full scale and sum to it
   `SGCM_ASSERT_IMPLY(weights_sum_full, clock, reset, valid1_ff, (weight_second_ff <= FULL_WEIGHT) && (weight_first_ff + weight_second_ff == FULL_WEIGHT), "blend weights out of range")

   // An input transfer always lands in stage 1
   `SGCM_ASSERT_NEXT(accept_fills_stage, clock, reset, req_bus.valid && req_bus.ready, valid1_ff, "accepted item missing from stage 1")

   // A new result only comes from an occupied multiply stage
   `SGCM_ASSERT_IMPLY(result_from_mul, clock, reset, $rose(valid3_ff), $past(valid2_ff), "result appeared without a multiply-stage item")

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench
   import sgcm_pkg::*;
;

   localparam int FRAC_BITS      = 8;
   localparam int FULL_SCALE     = 1 << FRAC_BITS;
   localparam int RANDOM_ITEMS   = 1780;
   localparam int CALM_TAIL      = 200;
   localparam int LONG_HOLD_AT   = 600;
   localparam int LONG_HOLD_LEN  = 80;
   localparam int DRAIN_AT       = 1000;
   localparam int WATCHDOG_LIMIT = 2000;

   // Exact curve constants: code c sits at (1000*c + 14025) / 269025 on the
   // shifted power segment, and codes below the knee linearize to zero
   localparam int unsigned KNOT_SCALE  = 1000;
   localparam int unsigned KNOT_OFFSET = 14025;
   localparam int unsigned KNOT_DENOM  = 269025;
   localparam int unsigned CODE_TOP    = 255;
   localparam int unsigned DECODE_KNEE = 11;

   typedef logic [319:0] wide_num_type;

   typedef struct packed {
      code_type             first_red;
      code_type             first_green;
      code_type             first_blue;
      code_type             second_red;
      code_type             second_green;
      code_type             second_blue;
      logic [FRAC_IN_W-1:0] blend_fraction;
      logic                 drain_first;
   } color_pair_type;

   typedef struct packed {
      code_type mixed_red;
      code_type mixed_green;
      code_type mixed_blue;
   } mixed_color_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sgcm_req_if req_bus ();
   sgcm_rsp_if rsp_bus ();

   srgb_gamma_color_mix_unit #(
      .FRACTION_BITS(FRAC_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   code_type        decode_curve [256];
   code_type        encode_curve [256];
   color_pair_type  pending_pairs [$];
   mixed_color_type expected_colors [$];
   color_pair_type  offered;

   int   total_items = 0;
   int   calm_start  = 0;
   int   sent_count  = 0;
   int   rsp_count   = 0;
   int   error_count = 0;
   int   quiet_cycles = 0;
   int   send_burst = 0, send_quiet = 0;
   int   recv_burst = 0, recv_quiet = 0;
   int   hold_left = 0;
   bit   long_hold_done = 1'b0;
   logic rsp_hold = 1'b0;

   // Free-running clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hold reset at the start, then release it
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // b5^5 * b12^12, built from squares
   function automatic wide_num_type power_mix(input int unsigned b5, input int unsigned b12);
      wide_num_type x2, x4, x8, y;
      x2 = wide_num_type'(b12) * wide_num_type'(b12);
      x4 = x2 * x2;
      x8 = x4 * x4;
      y  = wide_num_type'(b5) * wide_num_type'(b5);
      y  = y * y * wide_num_type'(b5);
      return x8 * x4 * y;
   endfunction

   // Derive both curves by exact comparison; every entry is a floor
   initial begin : build_curves
      wide_num_type knot [256];
      wide_num_type level [256];
      for (int i = 0; i < 256; i++) begin
         knot[i]  = power_mix(CODE_TOP, KNOT_SCALE * i + KNOT_OFFSET);
         level[i] = power_mix(i, KNOT_DENOM);
      end
      for (int i = 0; i < 256; i++) begin
         decode_curve[i] = '0;
         encode_curve[i] = '0;
         for (int c = 1; c < 256; c++) begin
            if (i >= DECODE_KNEE && level[c] <= knot[i]) decode_curve[i] = code_type'(c);
            if (i > 0 && knot[c] <= level[i]) encode_curve[i] = code_type'(c);
         end
      end
   end

   // Blend one channel in linear light and re-encode
   function automatic code_type blend_channel(input code_type a, input code_type b,
                                              input int unsigned weight);
      int unsigned lin;
      lin = (decode_curve[a] * (FULL_SCALE - weight) + decode_curve[b] * weight) >> FRAC_BITS;
      return encode_curve[lin % 256];
   endfunction

   function automatic mixed_color_type blend_colors(input color_pair_type p);
      int unsigned     weight;
      mixed_color_type m;
      weight = p.blend_fraction;
      // Saturate fractions above full scale to all of the second color
      if (weight > FULL_SCALE) weight = FULL_SCALE;
      m.mixed_red   = blend_channel(p.first_red, p.second_red, weight);
      m.mixed_green = blend_channel(p.first_green, p.second_green, weight);
      m.mixed_blue  = blend_channel(p.first_blue, p.second_blue, weight);
      return m;
   endfunction

   function automatic color_pair_type make_pair(input int unsigned fr, fg, fb, sr, sg, sb,
                                                input int unsigned frac);
      color_pair_type p;
      p.first_red      = code_type'(fr);
      p.first_green    = code_type'(fg);
      p.first_blue     = code_type'(fb);
      p.second_red     = code_type'(sr);
      p.second_green   = code_type'(sg);
      p.second_blue    = code_type'(sb);
      p.blend_fraction = frac[FRAC_IN_W-1:0];
      p.drain_first    = 1'b0;
      return p;
   endfunction

   task automatic report_error(input string text);
      $display("ERROR @%0t: %s", $realtime, text);
      error_count++;
   endtask

   // Advance one side's idle pattern: random bursts between quiet stretches
   task automatic advance_gaps(inout int burst, inout int quiet, input bit calm);
      if (calm) begin
         burst = 0;
         quiet = 0;
      end else if (burst > 0) begin
         burst--;
      end else if (quiet > 0) begin
         quiet--;
      end else if ($urandom_range(0, 2) == 0) begin
         burst = $urandom_range(1, 10);
      end else begin
         quiet = $urandom_range(0, 40);
      end
   endtask

   // Offer pending pairs; predict each one at its transfer
   always @(posedge clock) begin : request_driver
      logic next_valid;
      int   outstanding;
      if (reset) begin
         req_bus.valid          <= 1'b0;
         req_bus.first_red      <= '0;
         req_bus.first_green    <= '0;
         req_bus.first_blue     <= '0;
         req_bus.second_red     <= '0;
         req_bus.second_green   <= '0;
         req_bus.second_blue    <= '0;
         req_bus.blend_fraction <= '0;
      end else begin
         next_valid  = req_bus.valid;
         outstanding = sent_count - rsp_count;
         if (req_bus.valid && req_bus.ready) begin
            expected_colors.push_back(blend_colors(offered));
            sent_count <= sent_count + 1;
            outstanding++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            advance_gaps(send_burst, send_quiet, sent_count >= calm_start || rsp_hold);
            // Hold a drain-first pair until every result is back
            if (send_burst == 0 && pending_pairs.size() != 0 &&
                !(pending_pairs[0].drain_first && outstanding > 0)) begin
               offered = pending_pairs.pop_front();
               req_bus.first_red      <= offered.first_red;
               req_bus.first_green    <= offered.first_green;
               req_bus.first_blue     <= offered.first_blue;
               req_bus.second_red     <= offered.second_red;
               req_bus.second_green   <= offered.second_green;
               req_bus.second_blue    <= offered.second_blue;
               req_bus.blend_fraction <= offered.blend_fraction;
               next_valid = 1'b1;
            end
         end
         req_bus.valid <= next_valid;
      end
   end

   // Check each result transfer against the oldest prediction; pace ready
   always @(posedge clock) begin : response_monitor
      mixed_color_type want;
      logic            next_ready;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_colors.size() == 0) begin
               report_error($sformatf("result %0d arrived with nothing expected", rsp_count));
            end else begin
               want = expected_colors.pop_front();
               if (rsp_bus.mixed_red !== want.mixed_red)
                  report_error($sformatf("result %0d red: got %0d, want %0d", rsp_count,
                                         rsp_bus.mixed_red, want.mixed_red));
               if (rsp_bus.mixed_green !== want.mixed_green)
                  report_error($sformatf("result %0d green: got %0d, want %0d", rsp_count,
                                         rsp_bus.mixed_green, want.mixed_green));
               if (rsp_bus.mixed_blue !== want.mixed_blue)
                  report_error($sformatf("result %0d blue: got %0d, want %0d", rsp_count,
                                         rsp_bus.mixed_blue, want.mixed_blue));
            end
         end
         // Hold off once for a long stretch so the pipeline fills and stalls its input
         if (!long_hold_done && sent_count >= LONG_HOLD_AT) begin
            hold_left      = LONG_HOLD_LEN;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            advance_gaps(recv_burst, recv_quiet, sent_count >= calm_start);
            next_ready = (recv_burst == 0);
         end
         rsp_bus.ready <= next_ready;
         rsp_hold      <= (hold_left > 0);
      end
   end

   // Count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("no transfer for %0d cycles, giving up", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // Fill the pending queue, then wait for every result
   initial begin : stimulus
      color_pair_type item;
      int             directed;
      int             saturated;
      int unsigned    frac;
      saturated = 0;

      // Extremes, saturation, the linear knee and bit patterns
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(255, 255, 255, 255, 255, 255, 256));
      pending_pairs.push_back(make_pair(0, 0, 0, 255, 255, 255, 0));
      pending_pairs.push_back(make_pair(0, 0, 0, 255, 255, 255, 256));
      pending_pairs.push_back(make_pair(0, 0, 0, 255, 255, 255, 128));
      pending_pairs.push_back(make_pair(255, 255, 255, 0, 0, 0, 128));
      pending_pairs.push_back(make_pair(255, 0, 0, 0, 0, 255, 128));
      pending_pairs.push_back(make_pair(0, 255, 0, 255, 0, 255, 64));
      pending_pairs.push_back(make_pair(10, 11, 12, 10, 11, 12, 200));
      pending_pairs.push_back(make_pair(10, 11, 255, 11, 10, 0, 128));
      pending_pairs.push_back(make_pair(1, 2, 3, 254, 253, 252, 1));
      pending_pairs.push_back(make_pair(1, 2, 3, 254, 253, 252, 255));
      pending_pairs.push_back(make_pair(128, 64, 32, 16, 8, 4, 257));
      pending_pairs.push_back(make_pair(128, 64, 32, 16, 8, 4, 511));
      pending_pairs.push_back(make_pair(200, 100, 50, 50, 100, 200, 384));
      pending_pairs.push_back(make_pair(255, 128, 0, 0, 128, 255, 256));
      pending_pairs.push_back(make_pair(170, 85, 170, 85, 170, 85, 170));
      pending_pairs.push_back(make_pair(85, 170, 85, 170, 85, 170, 85));
      pending_pairs.push_back(make_pair(255, 0, 255, 0, 255, 0, 0));
      pending_pairs.push_back(make_pair(11, 11, 11, 255, 255, 255, 2));
      directed  = pending_pairs.size();
      saturated = 3;

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Mostly in range, some at the ends, some above full scale
         case ($urandom_range(0, 7))
            0:       frac = $urandom_range(0, 1) ? FULL_SCALE : 0;
            1:       frac = $urandom_range(FULL_SCALE + 1, 511);
            default: frac = $urandom_range(0, FULL_SCALE);
         endcase
         if (frac > FULL_SCALE) saturated++;
         item = make_pair($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255), frac);
         if ($urandom_range(0, 15) == 0) begin
            item.second_red   = item.first_red;
            item.second_green = item.first_green;
            item.second_blue  = item.first_blue;
         end
         item.drain_first = (i == 0 || i == DRAIN_AT);
         pending_pairs.push_back(item);
      end
      total_items = pending_pairs.size();
      calm_start  = total_items - CALM_TAIL;

      wait (!reset);
      do @(posedge clock);
      while (sent_count != total_items || rsp_count < total_items);
      repeat (20) @(posedge clock);
      if (expected_colors.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_colors.size()));

      $display("covered %0d blends (%0d directed), %0d with the fraction above full scale",
               total_items, directed, saturated);
      $display("output held off for %0d cycles once; input paused for a full drain twice",
               LONG_HOLD_LEN);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
